// ===== rtl/rgb_to_hue_saturation_defines.svh =====
// Assertion macros used by the RGB to hue/saturation RTL.
`ifndef RGB_TO_HUE_SATURATION_DEFINES_SVH
`define RGB_TO_HUE_SATURATION_DEFINES_SVH

`ifndef ASSERT_OFF
// Checks that a property holds at every clock edge outside reset.
`define RTHS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("rths assertion failed");
// Checks that a condition never holds outside reset.
`define RTHS_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("rths forbidden condition seen");
`else
`define RTHS_ASSERT(label, prop)
`define RTHS_NEVER(label, cond)
`endif

`endif

// ===== rtl/rths_pkg.sv =====
// Types, constants and the reciprocal table of the RGB to hue/saturation block.
package rths_pkg;

	localparam int ChanW    = 8;
	localparam int DenCount = 256;
	localparam int NumW     = 18;
	localparam int DivShift = 26;
	localparam int RecipW   = DivShift + 1;
	localparam int ProdW    = NumW + RecipW;
	localparam int QuotW    = 10;
	localparam int HueW     = 13;
	localparam int SatW     = 8;
	localparam int DataInW  = 24;
	localparam int DataOutW = 24;

	// Hue is counted in sixteenths of a degree.
	localparam logic [HueW-1:0] HueSixty  = HueW'(960);
	localparam logic [HueW-1:0] HueGreen  = HueW'(1920);
	localparam logic [HueW-1:0] HueBlue   = HueW'(3840);
	localparam logic [HueW-1:0] HueFull   = HueW'(5760);
	localparam logic [NumW-1:0] SatScale  = NumW'(255);

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	// Clock enables of the two divider stages.
	typedef struct packed {
		logic s1;
		logic s2;
	} div_ce_t;

	typedef logic [RecipW-1:0] recip_tab_t [DenCount];

	// ceil(2^DivShift / den) for every 8-bit divisor, built by long division at
	// elaboration. With this rounding, floor(num * recip >> DivShift) equals
	// floor(num / den) for every numerator below 2^NumW.
	function automatic recip_tab_t make_recip_tab();
		recip_tab_t tab;
		logic [RecipW:0] rem;
		logic [RecipW-1:0] quo;
		tab[0] = '0;
		for (int i = 1; i < DenCount; i++) begin
			rem = '0;
			quo = '0;
			for (int k = RecipW - 1; k >= 0; k--) begin
				rem = {rem[RecipW-1:0], 1'(k == DivShift)};
				if (rem >= (RecipW+1)'(i)) begin
					rem = rem - (RecipW+1)'(i);
					quo[k] = 1'b1;
				end
			end
			tab[i] = quo + RecipW'(rem != '0);
		end
		return tab;
	endfunction

	localparam recip_tab_t RecipTab = make_recip_tab();

endpackage

// ===== rtl/rths_div.sv =====
// Two-stage divider by an 8-bit divisor: reciprocal table lookup, then multiply.
module rths_div (
	input  logic                            clk,
	input  rths_pkg::div_ce_t               ce,
	input  logic [rths_pkg::NumW-1:0]       num,
	input  logic [rths_pkg::ChanW-1:0]      den,
	output logic [rths_pkg::QuotW-1:0]      quot
);
	import rths_pkg::*;

	logic [NumW-1:0]   num_s1;
	logic [RecipW-1:0] recip_s1;
	logic [ProdW-1:0]  prod_s2;

	always_ff @(posedge clk) begin
		if (ce.s1) begin
			num_s1   <= num;
			recip_s1 <= RecipTab[den];
		end
	end

	always_ff @(posedge clk) begin
		if (ce.s2) begin
			prod_s2 <= ProdW'(num_s1) * ProdW'(recip_s1);
		end
	end

	// Quotients stay at or below 960, so the bits above QuotW are zero.
	assign quot = prod_s2[DivShift +: QuotW];

endmodule

// ===== rtl/rgb_to_hue_saturation.sv =====
// Top level of the RGB to hue/saturation converter.
// Converts a stream of 8-bit RGB pixels into HSV hue and saturation.
// Input channel s_axis: one pixel per transaction, tdata holds red, green and
// blue from the lowest byte up. Output channel m_axis: one result per pixel,
// tdata holds hue (sixteenths of a degree, 0..5759) then saturation (0..255).
// A grey pixel gives hue 0 and saturation 0.
// An accepted input transaction passes through four register stages before
// its result is shown on m_axis. Throughput is one pixel per clock while the
// receiver keeps m_axis_tready high: the stages (range and sector, numerators
// and reciprocal lookup, multiply, final offset) each hold one pixel, and both
// divisions use a reciprocal table followed by one multiplier.
// Reset clears the valid bit of every stage; no pixel is in flight afterward.
// When the receiver holds m_axis_tready low, the result stays in the output
// stage; earlier stages keep filling any empty slots, and s_axis_tready drops
// only once every stage holds a pixel. Nothing is lost or repeated.
module rgb_to_hue_saturation (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// red [7:0], green [15:8], blue [23:16]
	input  logic [rths_pkg::DataInW-1:0]    s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// hue [12:0], saturation [20:13], zero [23:21]
	output logic [rths_pkg::DataOutW-1:0]   m_axis_tdata
);
	import rths_pkg::*;

	`include "rgb_to_hue_saturation_defines.svh"

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	// Each stage moves on when it is empty or the next one moves on.
	assign adv4 = !v_s4 || m_axis_tready;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign s_axis_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_axis_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// Stage 1: range, sector and the signed channel difference.
	logic [ChanW-1:0] red, green, blue;
	logic [ChanW-1:0] mx, mn, pos_ch, neg_ch;
	sector_t          sec;

	assign red   = s_axis_tdata[7:0];
	assign green = s_axis_tdata[15:8];
	assign blue  = s_axis_tdata[23:16];

	always_comb begin
		if (red >= green && red >= blue) begin
			sec    = SEC_RED;
			mx     = red;
			pos_ch = green;
			neg_ch = blue;
		end else if (green >= blue) begin
			sec    = SEC_GREEN;
			mx     = green;
			pos_ch = blue;
			neg_ch = red;
		end else begin
			sec    = SEC_BLUE;
			mx     = blue;
			pos_ch = red;
			neg_ch = green;
		end
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
	end

	logic [ChanW-1:0] mx_s1, d_s1, a_s1;
	logic             neg_s1;
	sector_t          sec_s1;

	always_ff @(posedge clk) begin
		if (adv1 && s_axis_tvalid) begin
			mx_s1  <= mx;
			d_s1   <= mx - mn;
			neg_s1 <= pos_ch < neg_ch;
			a_s1   <= (pos_ch >= neg_ch) ? pos_ch - neg_ch : neg_ch - pos_ch;
			sec_s1 <= sec;
		end
	end

	// Stage 2: numerators. A negative quotient is floored as minus the ceiling
	// of its magnitude, so d - 1 is added before the unsigned division.
	logic [NumW-1:0] hue_num, sat_num;

	assign hue_num = NumW'(a_s1) * NumW'(HueSixty)
		+ (neg_s1 ? NumW'(d_s1) - NumW'(1) : '0);
	assign sat_num = NumW'(d_s1) * SatScale;

	div_ce_t div_ce;
	assign div_ce.s1 = adv2 && v_s1;
	assign div_ce.s2 = adv3 && v_s2;

	logic [QuotW-1:0] hue_quot, sat_quot;

	rths_div u_hue_div (
		.clk  (clk),
		.ce   (div_ce),
		.num  (hue_num),
		.den  (d_s1),
		.quot (hue_quot)
	);

	rths_div u_sat_div (
		.clk  (clk),
		.ce   (div_ce),
		.num  (sat_num),
		.den  (mx_s1),
		.quot (sat_quot)
	);

	logic    grey_s2, neg_s2, grey_s3, neg_s3;
	sector_t sec_s2, sec_s3;

	always_ff @(posedge clk) begin
		if (div_ce.s1) begin
			grey_s2 <= d_s1 == '0;
			neg_s2  <= neg_s1;
			sec_s2  <= sec_s1;
		end
		if (div_ce.s2) begin
			grey_s3 <= grey_s2;
			neg_s3  <= neg_s2;
			sec_s3  <= sec_s2;
		end
	end

	// Stage 4: sector offset; a negative hue in the red sector wraps by 360 degrees.
	logic [HueW-1:0] base, hue;

	always_comb begin
		case (sec_s3)
			SEC_RED:   base = neg_s3 ? HueFull : '0;
			SEC_GREEN: base = HueGreen;
			SEC_BLUE:  base = HueBlue;
			default:   base = '0;
		endcase
		if (grey_s3) begin
			hue = '0;
		end else if (neg_s3) begin
			hue = base - HueW'(hue_quot);
		end else begin
			hue = base + HueW'(hue_quot);
		end
	end

	logic [HueW-1:0] hue_s4;
	logic [SatW-1:0] sat_s4;

	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			hue_s4 <= hue;
			sat_s4 <= grey_s3 ? '0 : sat_quot[SatW-1:0];
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {(DataOutW-HueW-SatW)'(0), sat_s4, hue_s4};

	`RTHS_NEVER(a_hue_range, m_axis_tvalid && m_axis_tdata[12:0] >= HueFull)
	`RTHS_ASSERT(a_grey_hue, m_axis_tvalid && m_axis_tdata[20:13] == '0 |-> m_axis_tdata[12:0] == '0)
	`RTHS_ASSERT(a_stage_fill, v_s3 && adv4 |=> v_s4)
	`RTHS_ASSERT(a_out_pad, m_axis_tdata[23:21] == '0)

endmodule

// ===== sim/rgb_to_hue_saturation_checker.sv =====
// Checker that predicts hue and saturation for every accepted pixel and compares results.
module rgb_to_hue_saturation_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	// red [7:0], green [15:8], blue [23:16]
	input  logic [rths_pkg::DataInW-1:0]  s_axis_tdata,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// hue [12:0], saturation [20:13], zero [23:21]
	input  logic [rths_pkg::DataOutW-1:0] m_axis_tdata,
	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import rths_pkg::*;

	typedef struct packed {
		logic [HueW-1:0] hue;
		logic [SatW-1:0] sat;
	} hue_sat_t;

	hue_sat_t hue_sat_q [$];
	int mismatches = 0;
	int waiting = 0;

	assign fail_count = mismatches;
	assign pending = waiting;

	function automatic hue_sat_t predict_hue_sat(input logic [DataInW-1:0] pix);
		hue_sat_t res;
		int r, g, b, mx, mn, d, num, base, q;
		r = int'(pix[ChanW-1:0]);
		g = int'(pix[2*ChanW-1:ChanW]);
		b = int'(pix[3*ChanW-1:2*ChanW]);
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		res = '0;
		if (d != 0) begin
			// Ties go to red first, then green.
			if (mx == r) begin
				num = 960 * (g - b);
				base = 0;
			end else if (mx == g) begin
				num = 960 * (b - r);
				base = 1920;
			end else begin
				num = 960 * (r - g);
				base = 3840;
			end
			// Integer division truncates toward zero; step down to get the floor.
			q = num / d;
			if ((num % d) != 0 && num < 0) q = q - 1;
			q = q + base;
			if (q < 0) q = q + 5760;
			res.hue = HueW'(q);
			res.sat = SatW'((255 * d) / mx);
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		hue_sat_t want;
		if (arst_n) begin
			// A result leaves only after its pixel has passed the pipeline registers, so check before pushing.
			if (m_axis_tvalid && m_axis_tready) begin
				if (hue_sat_q.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected, tdata 0x%06h",
						m_axis_tdata));
				end else begin
					want = hue_sat_q.pop_front();
					if (m_axis_tdata[HueW-1:0] !== want.hue)
						report_mismatch($sformatf("hue got %0d, expected %0d",
							m_axis_tdata[HueW-1:0], want.hue));
					if (m_axis_tdata[HueW+SatW-1:HueW] !== want.sat)
						report_mismatch($sformatf("saturation got %0d, expected %0d",
							m_axis_tdata[HueW+SatW-1:HueW], want.sat));
					if (m_axis_tdata[DataOutW-1:HueW+SatW] !== '0)
						report_mismatch($sformatf("padding bits not zero, tdata 0x%06h",
							m_axis_tdata));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				hue_sat_q.push_back(predict_hue_sat(s_axis_tdata));
			waiting = hue_sat_q.size();
		end
	end

endmodule

// ===== sim/tb_rgb_to_hue_saturation.sv =====
// Testbench top for the RGB to hue/saturation converter: stimulus, flow control and verdict.
module tb_rgb_to_hue_saturation;
	timeunit 1ns;
	timeprecision 1ps;

	import rths_pkg::*;

	typedef enum int {
		PH_MOSTLY_RX_STALL,
		PH_MOSTLY_TX_GAP,
		PH_NO_IDLE
	} idle_phase_t;

	localparam int PixPerPhase   = 460;
	localparam int HoldOffCycles = 64;
	localparam int StallLimit    = 2000;

	localparam logic [DataInW-1:0] DirectedPix [22] = '{
		24'h000000, 24'hFFFFFF, 24'h808080, 24'h0000FF, 24'h00FF00, 24'hFF0000,
		24'h00FFFF, 24'hFFFF00, 24'hFF00FF, 24'h0100FF, 24'hC80AFF, 24'h0A64C8,
		24'h3296FF, 24'h40F020, 24'hF01040, 24'h000001, 24'hFEFEFF, 24'h000100,
		24'h010000, 24'hFFFFFE, 24'h969664, 24'h000101
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [DataInW-1:0]   s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [DataOutW-1:0]  m_axis_tdata;
	int                   fail_count;
	int                   pending;
	idle_phase_t          phase = PH_MOSTLY_RX_STALL;

	rgb_to_hue_saturation u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	rgb_to_hue_saturation_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_pixel(input logic [DataInW-1:0] pix);
		int gap_pct;
		gap_pct = (phase == PH_MOSTLY_RX_STALL) ? 34 : (phase == PH_MOSTLY_TX_GAP) ? 86 : 0;
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= DataInW'($urandom);
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Receiver flow control; the first cycles of the no-idle phase hold off on purpose
	// so the pipeline fills and the input side stalls.
	initial begin : rx_flow
		idle_phase_t seen;
		int hold_left;
		int stall_pct;
		seen = PH_MOSTLY_RX_STALL;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (phase == PH_NO_IDLE && seen != PH_NO_IDLE) hold_left = HoldOffCycles;
			seen = phase;
			stall_pct = (phase == PH_MOSTLY_RX_STALL) ? 86 : (phase == PH_MOSTLY_TX_GAP) ? 34 : 0;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < StallLimit) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_rgb_to_hue_saturation NOT OK");
		$finish;
	end

	initial begin : stimulus
		logic [ChanW-1:0] ch [3];
		logic [ChanW-1:0] top_val;
		logic [ChanW-1:0] base_val;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DirectedPix[i]) send_pixel(DirectedPix[i]);

		for (int p = 0; p < 3; p++) begin
			phase = idle_phase_t'(p);
			for (int n = 0; n < PixPerPhase; n++) begin
				case ($urandom_range(9))
					0: begin
						// Grey pixel.
						top_val = ChanW'($urandom);
						ch = '{top_val, top_val, top_val};
					end
					1: begin
						// Two channels share the maximum.
						top_val = ChanW'($urandom_range(255, 1));
						ch = '{top_val, top_val, top_val};
						ch[$urandom_range(2)] = ChanW'($urandom_range(top_val - 1, 0));
					end
					2: begin
						// Nearly grey: the range is tiny, which stresses the division.
						base_val = ChanW'($urandom_range(253));
						foreach (ch[k]) ch[k] = base_val + ChanW'($urandom_range(2));
					end
					default: begin
						foreach (ch[k]) ch[k] = ChanW'($urandom);
					end
				endcase
				send_pixel({ch[2], ch[1], ch[0]});
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		if (fail_count == 0)
			$display("tb_rgb_to_hue_saturation OK");
		else
			$display("tb_rgb_to_hue_saturation NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rths_pkg.sv
rtl/rths_div.sv
rtl/rgb_to_hue_saturation.sv
sim/rgb_to_hue_saturation_checker.sv
sim/tb_rgb_to_hue_saturation.sv
